// ===== hdl/dpfc_pkg.sv =====
// ----------------------------------------------------------------------------
// dpfc_pkg: shared types and constants of the distinct prime factor counter
// Holds the result count type and its saturation limit.
// ----------------------------------------------------------------------------
`default_nettype none

package dpfc_pkg;

   // width of the result count
   localparam int COUNT_BITS = 3;

   typedef logic [COUNT_BITS-1:0] count_type;

   // the count saturates here
   localparam count_type TALLY_MAX = 3'd7;

endpackage : dpfc_pkg

`default_nettype wire

// ===== hdl/distinct_prime_factor_counter_top.sv =====
// ----------------------------------------------------------------------------
// distinct_prime_factor_counter_top: distinct prime factor count by trial division
// Bit-serial restoring divider swept over divisor 2 and odd trial divisors up to sqrt.
// ----------------------------------------------------------------------------
// One item at a time. Each trial division runs bit-serially through one
// restoring divider, one quotient bit per cycle, after a check of the
// divisor against the cofactor. Divisors 2, 3, 5, 7, ... are tried while
// d*d <= cofactor, and a divisor that divides is tried again once per
// repeated factor without a new check. The result sits in an output
// register; req_ready is high whenever no item is in progress, even while a
// result waits to be taken.
// ----------------------------------------------------------------------------
`default_nettype none

module distinct_prime_factor_counter_top #(
   parameter int NUMBER_BITS = 20
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_ready,
   input  wire  [NUMBER_BITS-1:0]             req_number,
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output logic [dpfc_pkg::COUNT_BITS-1:0]    rsp_prime_count
);

   // divisor width: enough for sqrt of the largest number plus odd stepping
   localparam int DW = NUMBER_BITS / 2 + 2;
   // width of the running divisor square
   localparam int SW = 2 * DW;
   // bit counter of one division
   localparam int CW = $clog2(NUMBER_BITS);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_CHECK = 2'd1;
   localparam logic [1:0] ST_DIV   = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   logic [1:0]             state_ff, state_in;
   logic [NUMBER_BITS-1:0] cof_ff, cof_in;
   logic [DW-1:0]          div_ff, div_in;
   logic [SW-1:0]          sq_ff, sq_in;
   logic [NUMBER_BITS-1:0] quo_ff, quo_in;
   logic [DW-1:0]          rem_ff, rem_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic                   hit_ff, hit_in;
   dpfc_pkg::count_type    tally_ff, tally_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   dpfc_pkg::count_type    rsp_count_ff, rsp_count_in;

   logic                   req_take;
   logic                   rsp_free;
   logic [DW:0]            rem_shift;
   logic                   rem_ge;
   logic [DW:0]            rem_diff;
   logic [DW-1:0]          rem_next;
   logic [NUMBER_BITS-1:0] quo_next;
   logic                   sq_fits;
   dpfc_pkg::count_type    tally_inc;

   assign req_ready       = (state_ff == ST_IDLE);
   assign req_take        = req_valid && req_ready;
   assign rsp_free        = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_prime_count = rsp_count_ff;

   // one restoring division step: shift in the next dividend bit, subtract
   assign rem_shift = {rem_ff, quo_ff[NUMBER_BITS-1]};
   assign rem_ge    = (rem_shift >= {1'b0, div_ff});
   assign rem_diff  = rem_ge ? (rem_shift - {1'b0, div_ff}) : rem_shift;
   assign rem_next  = rem_diff[DW-1:0];
   assign quo_next  = {quo_ff[NUMBER_BITS-2:0], rem_ge};

   // keep trying while d*d <= cofactor
   assign sq_fits = (sq_ff <= {{(SW-NUMBER_BITS){1'b0}}, cof_ff});

   // saturating tally increment
   assign tally_inc = (tally_ff != dpfc_pkg::TALLY_MAX) ?
                      (tally_ff + dpfc_pkg::count_type'(1)) : tally_ff;

   // sequence the trial division
   always_comb begin
      state_in     = state_ff;
      cof_in       = cof_ff;
      div_in       = div_ff;
      sq_in        = sq_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      hit_in       = hit_ff;
      tally_in     = tally_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_count_in = rsp_count_ff;

      case (state_ff)
         ST_IDLE: begin
            // load a new item, start at divisor 2
            if (req_take) begin
               cof_in   = req_number;
               div_in   = DW'(2);
               sq_in    = SW'(4);
               tally_in = '0;
               hit_in   = 1'b0;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (sq_fits) begin
               // start one division of the cofactor
               quo_in   = cof_ff;
               rem_in   = '0;
               cnt_in   = '0;
               state_in = ST_DIV;
            end else begin
               // a cofactor above one is a last prime
               if (cof_ff > NUMBER_BITS'(1)) begin
                  tally_in = tally_inc;
               end
               state_in = ST_DONE;
            end
         end
         ST_DIV: begin
            quo_in = quo_next;
            rem_in = rem_next;
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(NUMBER_BITS - 1)) begin
               if (rem_next == '0) begin
                  // divides: drop the factor, count it once, divide again
                  cof_in = quo_next;
                  quo_in = quo_next;
                  rem_in = '0;
                  cnt_in = '0;
                  hit_in = 1'b1;
                  if (!hit_ff) begin
                     tally_in = tally_inc;
                  end
               end else begin
                  // advance to the next odd divisor
                  hit_in   = 1'b0;
                  state_in = ST_CHECK;
                  if (div_ff == DW'(2)) begin
                     div_in = DW'(3);
                     sq_in  = SW'(9);
                  end else begin
                     div_in = div_ff + DW'(2);
                     sq_in  = sq_ff + {{(SW-DW-2){1'b0}}, div_ff, 2'b00} + SW'(4);
                  end
               end
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = tally_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         hit_ff       <= 1'b0;
         tally_ff     <= '0;
         cof_ff       <= '0;
         div_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         hit_ff       <= hit_in;
         tally_ff     <= tally_in;
         cof_ff       <= cof_in;
         div_ff       <= div_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      sq_ff        <= sq_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      cnt_ff       <= cnt_in;
      rsp_count_ff <= rsp_count_in;
   end

endmodule : distinct_prime_factor_counter_top

`default_nettype wire

// ===== sim/distinct_prime_factor_counter_top_test.sv =====
// ----------------------------------------------------------------------------
// distinct_prime_factor_counter_top_test: self-checking bench for the counter
// Drives numbers through the request channel, predicts the number of distinct
// prime factors of each by trial division, and checks every result in order
// while both channels idle and stall at random in several phases.
// ----------------------------------------------------------------------------

module distinct_prime_factor_counter_top_test;

   localparam int NUMBER_BITS = 20;
   localparam int unsigned NUMBER_LIMIT = 1 << NUMBER_BITS;
   // watchdog limit, sized for the slowest item, a large 20-bit prime
   localparam int IDLE_LIMIT = 60000;
   localparam int DRAIN_CYCLES = 64;
   localparam int RANDOM_ITEMS = 117;

   typedef logic [NUMBER_BITS-1:0] number_type;

   typedef struct {
      number_type          number;
      dpfc_pkg::count_type prime_count;
   } factor_result_type;

   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   number_type          req_number = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   dpfc_pkg::count_type rsp_prime_count;

   number_type        pending_numbers[$];
   factor_result_type awaited_counts[$];

   int         items_sent = 0;
   int         total_items = 1;
   int         results_checked = 0;
   int         mismatch_count = 0;
   int         idle_cycles = 0;
   logic [7:0] counts_seen = '0;

   // idle and stall percentages per phase: none, sender, receiver, both
   int send_idle_pct [4] = '{0, 60, 0, 23};
   int recv_stall_pct [4] = '{0, 0, 60, 23};
   int unsigned low_primes [11] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31};

   // zero and one, primes, prime squares, extremes, full tally
   int unsigned directed_numbers [23] = '{
      0, 1, 2, 3, 4, 6, 9, 25, 30, 49, 1024, 65536, 65537,
      349525, 699050, 524288, 510510, 1000000, 999983,
      1040399, 1042441, 1048573, 1048575
   };

   distinct_prime_factor_counter_top #(
      .NUMBER_BITS(NUMBER_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_number(req_number),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_prime_count(rsp_prime_count)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // count distinct primes by trial division, saturating at the count limit
   function automatic dpfc_pkg::count_type count_distinct_primes(number_type value);
      int unsigned rest;
      int unsigned divisor;
      int          tally;
      rest = value;
      tally = 0;
      if (rest >= 2) begin
         for (divisor = 2; divisor * divisor <= rest; divisor++) begin
            if (rest % divisor == 0) begin
               tally++;
               while (rest % divisor == 0)
                  rest = rest / divisor;
            end
         end
         if (rest > 1)
            tally++;
      end
      if (tally > int'(dpfc_pkg::TALLY_MAX))
         tally = int'(dpfc_pkg::TALLY_MAX);
      return dpfc_pkg::count_type'(tally);
   endfunction

   // map progress through the item list onto one of four idling phases
   function automatic int phase_of(int sent);
      int phase;
      phase = sent * 4 / total_items;
      return (phase > 3) ? 3 : phase;
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch: %s", what);
   endtask

   // driver: present the next pending item, hold it until accepted
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            awaited_counts.push_back(factor_result_type'{req_number,
                                     count_distinct_primes(req_number)});
            items_sent++;
         end
         if (!req_valid || req_ready) begin
            if (pending_numbers.size() > 0 &&
                $urandom_range(0, 99) >= send_idle_pct[phase_of(items_sent)]) begin
               req_number <= pending_numbers.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: check each accepted result against the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_counts.size() == 0) begin
               report_mismatch($sformatf("unexpected result, prime_count %0d",
                                         rsp_prime_count));
            end else begin
               factor_result_type head;
               head = awaited_counts.pop_front();
               results_checked++;
               counts_seen[head.prime_count] = 1'b1;
               if (rsp_prime_count !== head.prime_count)
                  report_mismatch($sformatf("number %0d: prime_count expected %0d, got %0d",
                                            head.number, head.prime_count, rsp_prime_count));
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct[phase_of(items_sent)]);
      end
   end

   // watchdog: give up when neither channel moves for too long
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
            $display("tb: failure");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin
      int unsigned value;
      int unsigned prime;
      int unsigned pick;
      int          rounds;

      // directed: zero and one, primes, prime squares, extremes, full tally
      foreach (directed_numbers[i])
         pending_numbers.push_back(number_type'(directed_numbers[i]));

      // random: mostly short work, some smooth numbers and full-range values
      repeat (RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            value = $urandom_range(0, 4095);
         end else if (pick < 60) begin
            value = $urandom_range(4096, 65535);
         end else if (pick < 75) begin
            value = 1;
            repeat (12) begin
               prime = low_primes[$urandom_range(0, 10)];
               if (value * prime < NUMBER_LIMIT)
                  value = value * prime;
            end
         end else if (pick < 85) begin
            value = $urandom & (NUMBER_LIMIT - 1);
         end else if (pick < 93) begin
            prime = low_primes[$urandom_range(0, 10)];
            value = prime;
            rounds = $urandom_range(1, 19);
            repeat (rounds) begin
               if (value * prime < NUMBER_LIMIT)
                  value = value * prime;
            end
         end else begin
            case ($urandom_range(0, 2))
               0: begin
                  value = $urandom_range(0, 2);
               end
               1: begin
                  value = 1 << $urandom_range(0, NUMBER_BITS - 1);
               end
               default: begin
                  value = (1 << $urandom_range(1, NUMBER_BITS)) - 1;
               end
            endcase
         end
         pending_numbers.push_back(number_type'(value));
      end
      total_items = pending_numbers.size();

      // hold reset, then release it for good
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // drain: every item checked, then a short quiet tail
      while (results_checked < total_items)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("summary: %0d numbers sent, %0d results checked, %0d mismatches",
               items_sent, results_checked, mismatch_count);
      $display("summary: prime counts observed (bit per count 7..0): %b", counts_seen);
      if (mismatch_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
